[rtl/spid_pkg.sv]
`default_nettype none

package spid_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_SETPOINT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_CENTRE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 3'd7;

    // reset values
    localparam logic [15:0] GAIN_P_RST        = 16'd1946;
    localparam logic [15:0] GAIN_I_RST        = 16'd0;
    localparam logic [15:0] GAIN_D_RST        = 16'd5120;
    localparam logic [7:0]  LINE_SETPOINT_RST = 8'd75;
    localparam logic [11:0] SERVO_CENTRE_RST  = 12'd1520;
    localparam logic [11:0] PULSE_MIN_RST     = 12'd1200;
    localparam logic [11:0] PULSE_MAX_RST     = 12'd1800;
    localparam logic [7:0]  JUMP_LIMIT_RST    = 8'd30;
    localparam logic [7:0]  LAST_TARGET_RST   = 8'd75;

    // integral clamp, Q.4
    localparam logic signed [19:0] INTEG_LIMIT     = 20'sd160000;
    localparam logic signed [19:0] INTEG_LIMIT_NEG = -20'sd160000;

    // reciprocals scaled by 2^18, exact while the quotient fits in 12 bits
    localparam logic [15:0] RECIP_6 = 16'd43691;
    localparam logic [15:0] RECIP_5 = 16'd52429;

    typedef struct packed {
        logic [11:0] centre;
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
    } pulse_cfg_t;

    typedef struct packed {
        logic [11:0]        steer;
        logic signed [15:0] raw;
    } pulse_res_t;

    function automatic logic [11:0] div6(input logic [14:0] x);
        logic [30:0] prod;
        begin
            prod = 31'({16'd0, x} * {15'd0, RECIP_6});
            return prod[29:18];
        end
    endfunction

    function automatic logic [11:0] div5(input logic [14:0] x);
        logic [30:0] prod;
        begin
            prod = 31'({16'd0, x} * {15'd0, RECIP_5});
            return prod[29:18];
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
        begin
            if (v > 25'sd32767)
                return 16'sh7fff;
            else if (v < -25'sd32768)
                return 16'sh8000;
            else
                return v[15:0];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/spid_if.sv]
`default_nettype none

interface spid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] centre_near;
    logic [7:0] centre_mid;
    logic [7:0] centre_far;

    modport source (output valid, output centre_near, output centre_mid,
                    output centre_far, input ready);
    modport sink (input valid, input centre_near, input centre_mid,
                  input centre_far, output ready);
endinterface

interface spid_out_if;
    logic               valid;
    logic               ready;
    logic [11:0]        steer_pulse;
    logic signed [15:0] raw_pulse;
    logic [7:0]         used_target;
    logic               jump_rejected;

    modport source (output valid, output steer_pulse, output raw_pulse,
                    output used_target, output jump_rejected, input ready);
    modport sink (input valid, input steer_pulse, input raw_pulse,
                  input used_target, input jump_rejected, output ready);
endinterface

`default_nettype wire

[rtl/spid_pulse_calc.sv]
`default_nettype none

module spid_pulse_calc
(
    input  wire logic signed [29:0] prod_p,
    input  wire logic signed [35:0] prod_i,
    input  wire logic signed [30:0] prod_d,
    input  wire spid_pkg::pulse_cfg_t cfg,
    output spid_pkg::pulse_res_t     res
);

    logic signed [36:0] acc;
    logic signed [36:0] acc_adj;
    logic signed [24:0] quot;
    logic signed [15:0] pid;
    logic signed [24:0] with_centre;
    logic signed [15:0] raw;
    logic signed [16:0] lim_min;
    logic signed [16:0] lim_max;
    logic signed [16:0] raw_ext;

    always_comb
    begin
        acc = 37'(prod_p) + 37'(prod_i) + 37'(prod_d);
        // round toward zero before the arithmetic shift
        acc_adj = acc[36] ? (acc + 37'sd4095) : acc;
        quot = acc_adj[36:12];
        pid = spid_pkg::sat16(quot);
        with_centre = 25'(pid) + $signed({13'd0, cfg.centre});
        raw = spid_pkg::sat16(with_centre);

        raw_ext = 17'(raw);
        lim_min = $signed({5'd0, cfg.pulse_min});
        lim_max = $signed({5'd0, cfg.pulse_max});

        res.raw = raw;
        if (raw_ext < lim_min)
            res.steer = cfg.pulse_min;
        else if (raw_ext > lim_max)
            res.steer = cfg.pulse_max;
        else
            res.steer = raw[11:0];
    end

endmodule

`default_nettype wire

[rtl/steering_servo_pid_controller.sv]
// steering servo pid controller
//
// sample_ch carries three lane-centre columns per camera frame (near, mid,
// far); result_ch returns one item per sample: the clamped servo pulse, the
// unclamped pulse, the target column used and a flag for a rejected jump.
// Both channels transfer on a rising edge with valid and ready high.
// Gains, setpoint, centre, pulse limits and jump limit are written via
// cfg_we / cfg_index / cfg_data; the block does not check for frames in
// flight, so the user must write them only while no frame is in flight.
// Each sample passes stages 0 to 3 and the output register. A new sample
// can be taken every cycle: the target/jump test, the bias filter with the
// integrator, the three gain multipliers and the final sum and clamp each
// sit in their own register stage, and each feedback loop (last target,
// last bias, integral) closes inside a single stage.
// When result_ch stalls, empty stages still fill, so sample_ch keeps taking
// transfers until all four stages and the output register hold items.
// Reset loads the default configuration, sets the last target to column 75
// and clears the bias history and the integral; no result is pending.

`default_nettype none

module steering_servo_pid_controller
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    spid_in_if.sink                         sample_ch,
    spid_out_if.source                      result_ch,
    input  wire logic                       cfg_we,
    input  wire logic [spid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spid_pkg::CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [15:0] gain_p_reg;
    logic [15:0] gain_i_reg;
    logic [15:0] gain_d_reg;
    logic [7:0]  line_setpoint_reg;
    logic [11:0] servo_centre_reg;
    logic [11:0] pulse_min_reg;
    logic [11:0] pulse_max_reg;
    logic [7:0]  jump_limit_reg;

    // loop state
    logic [7:0]         last_target_reg;
    logic signed [12:0] prev_bias_reg;
    logic signed [18:0] integral_reg;

    // stage registers
    logic               s0_valid_reg;
    logic [7:0]         near_reg;
    logic [7:0]         mid_reg;
    logic [7:0]         far_reg;

    logic               s1_valid_reg;
    logic [11:0]        s1_target_reg;
    logic [7:0]         s1_used_reg;
    logic               s1_rej_reg;

    logic               s2_valid_reg;
    logic signed [12:0] s2_bias_reg;
    logic signed [18:0] s2_integ_reg;
    logic signed [13:0] s2_diff_reg;
    logic [7:0]         s2_used_reg;
    logic               s2_rej_reg;

    logic               s3_valid_reg;
    logic signed [29:0] s3_prod_p_reg;
    logic signed [35:0] s3_prod_i_reg;
    logic signed [30:0] s3_prod_d_reg;
    logic [7:0]         s3_used_reg;
    logic               s3_rej_reg;

    logic               out_valid_reg;
    logic [11:0]        steer_reg;
    logic signed [15:0] raw_reg;
    logic [7:0]         used_reg;
    logic               rej_reg;

    // a stage loads when it is empty or the stage after it loads
    logic take_out;
    logic take3;
    logic take2;
    logic take1;
    logic take0;

    assign take_out = !out_valid_reg || result_ch.ready;
    assign take3    = !s3_valid_reg || take_out;
    assign take2    = !s2_valid_reg || take3;
    assign take1    = !s1_valid_reg || take2;
    assign take0    = !s0_valid_reg || take1;

    assign sample_ch.ready = take0;

    // stage 0 -> 1: weighted target and jump test
    logic [10:0]        wsum;
    logic [11:0]        target;
    logic [11:0]        last_q4;
    logic signed [12:0] delta;
    logic [11:0]        delta_mag;
    logic               rejected;
    logic [11:0]        used_q4;

    always_comb
    begin
        wsum = 11'({near_reg, 1'b0}) + 11'(near_reg) + 11'({mid_reg, 1'b0})
             + 11'(far_reg);
        target = spid_pkg::div6({wsum, 4'b0000});
        last_q4 = {last_target_reg, 4'b0000};
        delta = $signed({1'b0, target}) - $signed({1'b0, last_q4});
        delta_mag = delta[12] ? 12'(-delta) : delta[11:0];
        rejected = delta_mag > {jump_limit_reg, 4'b0000};
        used_q4 = rejected ? last_q4 : target;
    end

    // stage 1 -> 2: bias filter, integrator, difference
    logic signed [12:0] bias_raw;
    logic signed [15:0] filt_num;
    logic [14:0]        filt_mag;
    logic [11:0]        filt_quot;
    logic signed [12:0] bias;
    logic signed [19:0] integ_sum;
    logic signed [18:0] integ;
    logic signed [13:0] diff;

    always_comb
    begin
        bias_raw = $signed({1'b0, line_setpoint_reg, 4'b0000})
                 - $signed({1'b0, s1_target_reg});
        filt_num = $signed({bias_raw[12], bias_raw, 2'b00}) + 16'(prev_bias_reg);
        filt_mag = filt_num[15] ? 15'(-filt_num) : filt_num[14:0];
        filt_quot = spid_pkg::div5(filt_mag);
        // division truncates toward zero, so divide the magnitude
        bias = filt_num[15] ? -$signed({1'b0, filt_quot})
                            : $signed({1'b0, filt_quot});
        integ_sum = 20'(integral_reg) + 20'(bias);
        if (integ_sum > spid_pkg::INTEG_LIMIT)
            integ = spid_pkg::INTEG_LIMIT[18:0];
        else if (integ_sum < spid_pkg::INTEG_LIMIT_NEG)
            integ = spid_pkg::INTEG_LIMIT_NEG[18:0];
        else
            integ = integ_sum[18:0];
        diff = 14'(bias) - 14'(prev_bias_reg);
    end

    // stage 3 -> out: sum, scale, saturate, clamp
    spid_pkg::pulse_cfg_t pulse_cfg;
    spid_pkg::pulse_res_t pulse_res;

    assign pulse_cfg.centre    = servo_centre_reg;
    assign pulse_cfg.pulse_min = pulse_min_reg;
    assign pulse_cfg.pulse_max = pulse_max_reg;

    spid_pulse_calc u_pulse_calc
    (
        .prod_p (s3_prod_p_reg),
        .prod_i (s3_prod_i_reg),
        .prod_d (s3_prod_d_reg),
        .cfg    (pulse_cfg),
        .res    (pulse_res)
    );

    // control, configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg        <= spid_pkg::GAIN_P_RST;
            gain_i_reg        <= spid_pkg::GAIN_I_RST;
            gain_d_reg        <= spid_pkg::GAIN_D_RST;
            line_setpoint_reg <= spid_pkg::LINE_SETPOINT_RST;
            servo_centre_reg  <= spid_pkg::SERVO_CENTRE_RST;
            pulse_min_reg     <= spid_pkg::PULSE_MIN_RST;
            pulse_max_reg     <= spid_pkg::PULSE_MAX_RST;
            jump_limit_reg    <= spid_pkg::JUMP_LIMIT_RST;
            last_target_reg   <= spid_pkg::LAST_TARGET_RST;
            prev_bias_reg     <= '0;
            integral_reg      <= '0;
            s0_valid_reg      <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    spid_pkg::REG_GAIN_P:        gain_p_reg        <= cfg_data;
                    spid_pkg::REG_GAIN_I:        gain_i_reg        <= cfg_data;
                    spid_pkg::REG_GAIN_D:        gain_d_reg        <= cfg_data;
                    spid_pkg::REG_LINE_SETPOINT: line_setpoint_reg <= cfg_data[7:0];
                    spid_pkg::REG_SERVO_CENTRE:  servo_centre_reg  <= cfg_data[11:0];
                    spid_pkg::REG_PULSE_MIN:     pulse_min_reg     <= cfg_data[11:0];
                    spid_pkg::REG_PULSE_MAX:     pulse_max_reg     <= cfg_data[11:0];
                    spid_pkg::REG_JUMP_LIMIT:    jump_limit_reg    <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            if (take0)
                s0_valid_reg <= sample_ch.valid;
            if (take1)
                s1_valid_reg <= s0_valid_reg;
            if (take2)
                s2_valid_reg <= s1_valid_reg;
            if (take3)
                s3_valid_reg <= s2_valid_reg;
            if (take_out)
                out_valid_reg <= s3_valid_reg;

            if (s0_valid_reg && take1)
                last_target_reg <= used_q4[11:4];
            if (s1_valid_reg && take2)
            begin
                prev_bias_reg <= bias;
                integral_reg  <= integ;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take0)
        begin
            near_reg <= sample_ch.centre_near;
            mid_reg  <= sample_ch.centre_mid;
            far_reg  <= sample_ch.centre_far;
        end
        if (take1)
        begin
            s1_target_reg <= used_q4;
            s1_used_reg   <= used_q4[11:4];
            s1_rej_reg    <= rejected;
        end
        if (take2)
        begin
            s2_bias_reg  <= bias;
            s2_integ_reg <= integ;
            s2_diff_reg  <= diff;
            s2_used_reg  <= s1_used_reg;
            s2_rej_reg   <= s1_rej_reg;
        end
        if (take3)
        begin
            s3_prod_p_reg <= $signed({1'b0, gain_p_reg}) * s2_bias_reg;
            s3_prod_i_reg <= $signed({1'b0, gain_i_reg}) * s2_integ_reg;
            s3_prod_d_reg <= $signed({1'b0, gain_d_reg}) * s2_diff_reg;
            s3_used_reg   <= s2_used_reg;
            s3_rej_reg    <= s2_rej_reg;
        end
        if (take_out)
        begin
            steer_reg <= pulse_res.steer;
            raw_reg   <= pulse_res.raw;
            used_reg  <= s3_used_reg;
            rej_reg   <= s3_rej_reg;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.steer_pulse   = steer_reg;
    assign result_ch.raw_pulse     = raw_reg;
    assign result_ch.used_target   = used_reg;
    assign result_ch.jump_rejected = rej_reg;

    // integrator never leaves its clamp range
    assert property (@(posedge clk) disable iff (!rst_n)
        (20'(integral_reg) <= spid_pkg::INTEG_LIMIT)
        && (20'(integral_reg) >= spid_pkg::INTEG_LIMIT_NEG))
        else $error("integral out of range");

    // a rejected jump keeps the last target
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && take1 && rejected) |=> $stable(last_target_reg))
        else $error("last target changed on rejected jump");

    // with no result pending every stage can move, so input is open
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample_ch.ready)
        else $error("input blocked with empty output");

    // a result transfer with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_ch.ready && !s3_valid_reg) |=> !out_valid_reg)
        else $error("result repeated");

endmodule

`default_nettype wire
